// ----- design/sva_pkg.sv -----
`default_nettype none
package sva_pkg;
   localparam int NumVoices = 32;
   localparam int FracBits  = 16;
   localparam int VoiceW    = 5;
   localparam int CountW    = 6;
   localparam int PosW      = 40;
   localparam int LenW      = 24;
   localparam int EnvW      = 25;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 25;
   localparam logic [EnvW-1:0] EnvOne = 25'h1000000;

   typedef enum logic [2:0] {
      CSR_HAT_CLOSED = 3'd0,
      CSR_HAT_TIGHT  = 3'd1,
      CSR_HAT_PEDAL  = 3'd2,
      CSR_OPEN_LOW   = 3'd3,
      CSR_OPEN_HIGH  = 3'd4,
      CSR_CHINA      = 3'd5,
      CSR_SPLASH     = 3'd6,
      CSR_ENV_FLOOR  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      RULE_NONE  = 2'd0,
      RULE_CLOSE = 2'd1,
      RULE_OPEN  = 2'd2,
      RULE_SELF  = 2'd3
   } rule_type;

   typedef struct packed {
      logic        func;
      logic [5:0]  articulation;
      logic        first_of_note;
      logic [23:0] length_frames;
      logic [23:0] rate_step;
      logic [24:0] decay_factor;
   } req_type;

   typedef struct packed {
      logic [4:0]  voice_index;
      logic        was_stolen;
      logic [5:0]  choked_count;
      logic [5:0]  active_count;
      logic [31:0] ended_mask;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch request, clear accumulators
      logic scan;     // process voice at scan_idx
      logic commit;   // write the start item into chosen voice
      logic [VoiceW-1:0] scan_idx;
      logic first;    // first scan entry
   } cmd_type;
endpackage
`default_nettype wire

// ----- design/sva_if.sv -----
`default_nettype none
interface sva_req_if;
   logic valid;
   logic ready;
   sva_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sva_rsp_if;
   logic valid;
   logic ready;
   sva_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/sva_ctrl.sv -----
`default_nettype none
module sva_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sva_pkg::cmd_type      cmd
);
   typedef enum logic [1:0] {IDLE, SCAN, COMMIT, OUTPUT} state_type;
   state_type state_ff;
   logic [sva_pkg::VoiceW-1:0] idx_ff;

   assign req_ready    = (state_ff == IDLE);
   assign rsp_valid    = (state_ff == OUTPUT);
   assign cmd.load     = req_valid && req_ready;
   assign cmd.scan     = (state_ff == SCAN);
   assign cmd.commit   = (state_ff == COMMIT);
   assign cmd.scan_idx = idx_ff;
   assign cmd.first    = (idx_ff == '0);

   // sequencer: one voice per cycle, then commit, then hold the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  state_ff <= SCAN;
                  idx_ff   <= '0;
               end
            end
            SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == sva_pkg::VoiceW'(sva_pkg::NumVoices - 1)) state_ff <= COMMIT;
            end
            COMMIT: state_ff <= OUTPUT;
            OUTPUT: if (rsp_ready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- design/sva_datapath.sv -----
`default_nettype none
module sva_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sva_pkg::cmd_type  cmd,
   input  wire sva_pkg::req_type  req,
   input  wire logic              csr_write_enable,
   input  wire logic [sva_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [sva_pkg::CsrDataW-1:0] csr_write_data,
   output sva_pkg::rsp_type       rsp
);
   localparam int NV = sva_pkg::NumVoices;
   localparam int FB = sva_pkg::FracBits;
   localparam int PW = sva_pkg::PosW;
   localparam int LW = sva_pkg::LenW;
   localparam int EW = sva_pkg::EnvW;
   localparam int VW = sva_pkg::VoiceW;
   localparam int CW = sva_pkg::CountW;

   // configuration
   logic [5:0] closed_ff, tight_ff, pedal_ff, olow_ff, ohigh_ff, china_ff, splash_ff;
   logic [EW-1:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= '0; tight_ff <= '0; pedal_ff <= '0;
         olow_ff <= '0; ohigh_ff <= '0;
         china_ff <= 6'd63; splash_ff <= 6'd63; floor_ff <= EW'(1678);
      end else if (csr_write_enable) begin
         case (sva_pkg::csr_index_type'(csr_index))
            sva_pkg::CSR_HAT_CLOSED: closed_ff <= csr_write_data[5:0];
            sva_pkg::CSR_HAT_TIGHT:  tight_ff  <= csr_write_data[5:0];
            sva_pkg::CSR_HAT_PEDAL:  pedal_ff  <= csr_write_data[5:0];
            sva_pkg::CSR_OPEN_LOW:   olow_ff   <= csr_write_data[5:0];
            sva_pkg::CSR_OPEN_HIGH:  ohigh_ff  <= csr_write_data[5:0];
            sva_pkg::CSR_CHINA:      china_ff  <= csr_write_data[5:0];
            sva_pkg::CSR_SPLASH:     splash_ff <= csr_write_data[5:0];
            sva_pkg::CSR_ENV_FLOOR:  floor_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // voice table
   logic [NV-1:0] live_ff;
   logic [5:0]    artic_ff [NV];
   logic [PW-1:0] pos_ff   [NV];
   logic [LW-1:0] len_ff   [NV];
   logic [LW-1:0] step_ff  [NV];
   logic [EW-1:0] env_ff   [NV];
   logic [EW-1:0] decay_ff [NV];

   // transaction state
   sva_pkg::req_type req_ff;
   sva_pkg::rule_type rule_ff;
   logic [CW-1:0] choked_ff;
   logic [31:0]   ended_ff;
   logic          free_found_ff;
   logic [VW-1:0] free_idx_ff, best_idx_ff;
   logic [PW-1:0] best_num_ff;
   logic [LW-1:0] best_den_ff;
   logic [VW-1:0] target_ff;
   logic          stolen_ff;

   function automatic logic in_open(input logic [5:0] a, input logic [5:0] lo,
                                    input logic [5:0] hi);
      in_open = (a >= lo) && (a <= hi);
   endfunction

   // rule from the incoming request, latched at load
   sva_pkg::rule_type rule_in;
   always_comb begin
      logic [5:0] a;
      a = req.articulation;
      if (a == closed_ff || a == tight_ff || a == pedal_ff) rule_in = sva_pkg::RULE_CLOSE;
      else if (in_open(a, olow_ff, ohigh_ff))               rule_in = sva_pkg::RULE_OPEN;
      else if (a == china_ff || a == splash_ff)             rule_in = sva_pkg::RULE_SELF;
      else                                                  rule_in = sva_pkg::RULE_NONE;
   end

   // per-voice scan datapath
   logic [VW-1:0] si;
   logic [5:0]    v_artic;
   logic          v_live, hit, live_after;
   logic [PW-1:0] v_pos, np, c_num;
   logic [LW-1:0] v_len, c_den;
   logic [PW:0]   pos_sum;
   logic [PW-FB:0] ip1;
   logic [2*EW-1:0] env_prod;
   logic [EW-1:0]  new_env;
   logic [PW+LW-1:0] lhs, rhs;
   logic          tick_end_len, tick_end_env;

   always_comb begin
      si       = cmd.scan_idx;
      v_live   = live_ff[si];
      v_artic  = artic_ff[si];
      v_pos    = pos_ff[si];
      v_len    = len_ff[si];
      case (rule_ff)
         sva_pkg::RULE_CLOSE: hit = in_open(v_artic, olow_ff, ohigh_ff);
         sva_pkg::RULE_OPEN:  hit = in_open(v_artic, olow_ff, ohigh_ff)
                                    && (v_artic != req_ff.articulation);
         sva_pkg::RULE_SELF:  hit = (v_artic == req_ff.articulation);
         default:             hit = 1'b0;
      endcase
      hit        = hit && v_live && req_ff.first_of_note;
      live_after = v_live && !hit;
      // progress for stealing
      if (v_len == '0) begin
         c_num = PW'(1) << FB;
         c_den = LW'(1);
      end else begin
         c_num = v_pos;
         c_den = v_len;
      end
      lhs = c_num * best_den_ff;
      rhs = best_num_ff * c_den;
      // tick
      ip1          = (PW-FB+1)'(v_pos >> FB) + 1'b1;
      tick_end_len = ip1 >= (PW-FB+1)'(v_len);
      pos_sum      = {1'b0, v_pos} + (PW+1)'(step_ff[si]);
      np           = pos_sum[PW] ? '1 : pos_sum[PW-1:0];
      env_prod     = env_ff[si] * decay_ff[si];
      new_env      = env_prod[EW+23:24];
      tick_end_env = new_env < floor_ff;
   end

   logic [EW-1:0] decay_sat;
   assign decay_sat = (req_ff.decay_factor > sva_pkg::EnvOne) ? sva_pkg::EnvOne
                                                              : req_ff.decay_factor;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         for (int i = 0; i < NV; i++) begin
            artic_ff[i] <= '0; pos_ff[i] <= '0; len_ff[i] <= '0;
            step_ff[i] <= '0; env_ff[i] <= '0; decay_ff[i] <= '0;
         end
      end else if (cmd.scan && req_ff.func) begin
         // tick one voice
         if (v_live) begin
            if (tick_end_len) live_ff[si] <= 1'b0;
            else begin
               pos_ff[si] <= np;
               env_ff[si] <= new_env;
               if (tick_end_env) live_ff[si] <= 1'b0;
            end
         end
      end else if (cmd.scan) begin
         if (hit) live_ff[si] <= 1'b0;
      end else if (cmd.commit && !req_ff.func) begin
         live_ff[target_ff]  <= 1'b1;
         artic_ff[target_ff] <= req_ff.articulation;
         pos_ff[target_ff]   <= '0;
         len_ff[target_ff]   <= req_ff.length_frames;
         step_ff[target_ff]  <= req_ff.rate_step;
         env_ff[target_ff]   <= sva_pkg::EnvOne;
         decay_ff[target_ff] <= decay_sat;
      end
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff        <= req;
         rule_ff       <= rule_in;
         choked_ff     <= '0;
         ended_ff      <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         best_idx_ff   <= '0;
         best_num_ff   <= '0;
         best_den_ff   <= LW'(1);
      end else if (cmd.scan) begin
         if (req_ff.func) begin
            if (v_live && (tick_end_len || tick_end_env)) ended_ff[si] <= 1'b1;
         end else begin
            if (hit) choked_ff <= choked_ff + 1'b1;
            if (!live_after && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= si;
            end
            if (cmd.first || lhs > rhs) begin
               best_num_ff <= c_num;
               best_den_ff <= c_den;
               best_idx_ff <= si;
            end
         end
      end
   end

   // target fixed at the last scan cycle
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         target_ff <= free_found_ff ? free_idx_ff
                    : (!live_after ? si
                    : ((lhs > rhs) ? si : best_idx_ff));
         stolen_ff <= !free_found_ff && live_after;
      end
   end

   // result
   always_comb begin
      rsp.voice_index  = req_ff.func ? '0 : target_ff;
      rsp.was_stolen   = req_ff.func ? 1'b0 : stolen_ff;
      rsp.choked_count = req_ff.func ? '0 : choked_ff;
      rsp.active_count = CW'($countones(live_ff));
      rsp.ended_mask   = ended_ff;
   end
endmodule
`default_nettype wire

// ----- design/sampler_voice_allocator_choke_top.sv -----
// Sampler voice allocator with choke groups.
// req channel: one transaction is a start (func 0) or a tick (func 1) item.
// rsp channel: exactly one result transaction per request transaction.
// csr port: csr_write_enable, csr_index, csr_write_data; write only while idle.
// Each item is scanned one voice per cycle through the shared per-voice
// datapath, then passes the commit state; rsp_valid rises in the output state
// that follows, and the result is handed off when rsp_ready is seen there.
// Only one item is in flight; req_ready is low until the result is taken.
// A stalled receiver holds the result stable and holds off new requests.
// Synchronous reset clears all voices and sets the registers to defaults
// (china and splash 63, envelope floor 1678, the rest zero); no clearing pass.
`default_nettype none
module sampler_voice_allocator_choke_top (
   input  wire logic clock,
   input  wire logic reset,
   sva_req_if.sink   req,
   sva_rsp_if.source rsp,
   input  wire logic csr_write_enable,
   input  wire logic [sva_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [sva_pkg::CsrDataW-1:0] csr_write_data
);
   sva_pkg::cmd_type cmd;

   sva_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .cmd
   );

   sva_datapath u_dp (
      .clock, .reset, .cmd,
      .req (req.payload),
      .csr_write_enable, .csr_index, .csr_write_data,
      .rsp (rsp.payload)
   );

   // no acceptance while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("request accepted with result pending");
   // a start result that stole a voice never reports ended voices
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.was_stolen) |-> (rsp.payload.ended_mask == '0))
      else $error("start reported ended voices");
   // active count bounded
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.payload.active_count <= 6'd32)) else $error("count overflow");
endmodule
`default_nettype wire
